### rtl/assert_macros.svh
// Assertion helpers for the page replacement block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted.
`define PRRO_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define PRRO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PRRO_ASSERT(lbl, clk, rstn, prop, msg)
`define PRRO_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### rtl/prro_pkg.sv
`default_nettype none
package prro_pkg;

  localparam int MAX_PAGES   = 16;
  localparam int TRACE_DEPTH = 1024;
  localparam int PAGE_BITS   = 16;

  localparam int IDX_W   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int CNT_W   = $clog2(MAX_PAGES + 1);
  localparam int TADDR_W = $clog2(TRACE_DEPTH);
  localparam int TLEN_W  = $clog2(TRACE_DEPTH + 1);

  localparam int PAGE_W = 16;
  localparam int CAP_W  = 5;
  localparam int FCNT_W = 32;
  localparam int RCNT_W = 5;
  localparam int CFG_W  = 16;
  localparam int CFG_AW = 2;
  localparam int LFSR_W = 16;
  localparam int MCNT_W = $clog2(LFSR_W);

  localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

  localparam logic [CFG_AW-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_SEED     = 2'd1;

  localparam logic CMD_ACCESS  = 1'b0;
  localparam logic CMD_RUN_OPT = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_ACC_LOOK,
    OP_MOD_STEP,
    OP_ACC_REPL,
    OP_OPT_INIT,
    OP_RD_I,
    OP_LOAD_PG,
    OP_OPT_LOOK,
    OP_NEXT_I,
    OP_SCAN_RD,
    OP_SCAN_CMP,
    OP_VSEL_STEP,
    OP_OPT_REPL,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e op;
  } prro_cmd_t;

  typedef struct packed {
    logic is_opt;
    logic hit;
    logic room;
    logic mod_last;
    logic trace_end;
    logic scan_end;
    logic vsel_end;
    logic out_free;
  } prro_stat_t;

endpackage
`default_nettype wire

### rtl/prro_ctrl.sv
`default_nettype none
module prro_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  prro_pkg::prro_stat_t  stat_i,
  output prro_pkg::prro_cmd_t   cmd_o
);
  import prro_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_AREPL = 4'd3;
  localparam logic [3:0] S_RD    = 4'd4;
  localparam logic [3:0] S_PG    = 4'd5;
  localparam logic [3:0] S_OLOOK = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_SRD   = 4'd8;
  localparam logic [3:0] S_SCMP  = 4'd9;
  localparam logic [3:0] S_VSEL  = 4'd10;
  localparam logic [3:0] S_OREPL = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NOP;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (stat_i.is_opt) begin
          cmd_o.op = OP_OPT_INIT;
          state_d  = S_RD;
        end else begin
          cmd_o.op = OP_ACC_LOOK;
          state_d  = (stat_i.hit || stat_i.room) ? S_OUT : S_MOD;
        end
      end
      S_MOD: begin
        cmd_o.op = OP_MOD_STEP;
        if (stat_i.mod_last) state_d = S_AREPL;
      end
      S_AREPL: begin
        cmd_o.op = OP_ACC_REPL;
        state_d  = S_OUT;
      end
      S_RD: begin
        if (stat_i.trace_end) begin
          state_d = S_OUT;
        end else begin
          cmd_o.op = OP_RD_I;
          state_d  = S_PG;
        end
      end
      S_PG: begin
        cmd_o.op = OP_LOAD_PG;
        state_d  = S_OLOOK;
      end
      S_OLOOK: begin
        cmd_o.op = OP_OPT_LOOK;
        state_d  = (stat_i.hit || stat_i.room) ? S_NEXT : S_SRD;
      end
      S_NEXT: begin
        cmd_o.op = OP_NEXT_I;
        state_d  = S_RD;
      end
      S_SRD: begin
        if (stat_i.scan_end) begin
          state_d = S_VSEL;
        end else begin
          cmd_o.op = OP_SCAN_RD;
          state_d  = S_SCMP;
        end
      end
      S_SCMP: begin
        cmd_o.op = OP_SCAN_CMP;
        state_d  = S_SRD;
      end
      S_VSEL: begin
        cmd_o.op = OP_VSEL_STEP;
        if (stat_i.vsel_end) state_d = S_OREPL;
      end
      S_OREPL: begin
        cmd_o.op = OP_OPT_REPL;
        state_d  = S_NEXT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

### rtl/prro_dp.sv
`default_nettype none
module prro_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [prro_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [prro_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                         cmd_i,
  input  logic [prro_pkg::PAGE_W-1:0]  page_i,
  input  prro_pkg::prro_cmd_t          ctl_i,
  output prro_pkg::prro_stat_t         stat_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         fault_o,
  output logic [prro_pkg::FCNT_W-1:0]  fault_count_o,
  output logic [prro_pkg::RCNT_W-1:0]  resident_count_o,
  output logic                         trace_overflow_o
);
  import prro_pkg::*;
  `include "assert_macros.svh"

  // configuration and long-lived state
  logic [CAP_W-1:0]     cap_q;
  logic [LFSR_W-1:0]    lfsr_q;
  logic [CNT_W-1:0]     used_q;
  logic [FCNT_W-1:0]    fault_total_q;
  logic [TLEN_W-1:0]    len_q;
  logic [PAGE_BITS-1:0] res_q [MAX_PAGES];

  // per item
  logic                 is_opt_q;
  logic                 fault_q;
  logic                 ovf_q;
  logic [PAGE_BITS-1:0] pg_q;

  // remainder unit
  logic [CNT_W-1:0]     rem_q;
  logic [LFSR_W-1:0]    sh_q;
  logic [MCNT_W-1:0]    mcnt_q;

  // replay
  logic [TLEN_W-1:0]    i_q, k_q;
  logic [MAX_PAGES-1:0] found_q;
  logic [TLEN_W-1:0]    next_q [MAX_PAGES];
  logic [TLEN_W-1:0]    far_q;
  logic                 have_q;
  logic [IDX_W-1:0]     vj_q, victim_q;

  // trace store
  logic [PAGE_BITS-1:0] tmem [TRACE_DEPTH];
  logic [PAGE_BITS-1:0] rdata_q;
  logic [TLEN_W-1:0]    raddr;

  // result register
  logic                 out_valid_q;
  logic                 o_fault_q, o_ovf_q;
  logic [FCNT_W-1:0]    o_fcnt_q;
  logic [CNT_W-1:0]     o_used_q;

  logic [CNT_W-1:0]     cap_eff;
  logic [MAX_PAGES-1:0] match;
  logic                 hit;
  logic [IDX_W-1:0]     pos;
  logic [CNT_W-1:0]     lim;
  logic [LFSR_W-1:0]    lfsr_step;
  logic [CNT_W:0]       rem_t;
  logic [CNT_W-1:0]     rem_d;
  logic                 all_found;
  logic [FCNT_W-1:0]    fault_inc;
  logic [IDX_W-1:0]     last_idx;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(cap_q) > MAX_PAGES) begin
      cap_eff = CNT_W'(MAX_PAGES);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  always_comb begin
    pos = '0;
    for (int j = MAX_PAGES - 1; j >= 0; j--) begin
      match[j] = (j < int'(used_q)) && (res_q[j] == pg_q);
      if (match[j]) pos = IDX_W'(j);
    end
    hit = |match;
    lim = hit ? CNT_W'(pos) : used_q;
  end

  always_comb begin
    all_found = 1'b1;
    for (int j = 0; j < MAX_PAGES; j++) begin
      if (j < int'(used_q) && !found_q[j]) all_found = 1'b0;
    end
  end

  assign lfsr_step = {1'b0, lfsr_q[LFSR_W-1:1]} ^ (lfsr_q[0] ? LFSR_MASK : '0);
  assign rem_t     = {rem_q, sh_q[LFSR_W-1]};
  assign rem_d     = (rem_t >= {1'b0, cap_eff}) ? CNT_W'(rem_t - {1'b0, cap_eff})
                                                 : CNT_W'(rem_t);
  assign fault_inc = (fault_total_q != '1) ? fault_total_q + FCNT_W'(1) : fault_total_q;
  assign last_idx  = IDX_W'(used_q - CNT_W'(1));
  assign raddr     = (ctl_i.op == OP_SCAN_RD) ? k_q : i_q;

  assign stat_o.is_opt    = is_opt_q;
  assign stat_o.hit       = hit;
  assign stat_o.room      = used_q < cap_eff;
  assign stat_o.mod_last  = mcnt_q == MCNT_W'(LFSR_W - 1);
  assign stat_o.trace_end = i_q >= len_q;
  assign stat_o.scan_end  = (k_q >= len_q) || all_found;
  assign stat_o.vsel_end  = !found_q[vj_q] || (vj_q == last_idx);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // trace store: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.op == OP_LATCH && cmd_i == CMD_ACCESS && int'(len_q) < TRACE_DEPTH) begin
      tmem[len_q[TADDR_W-1:0]] <= page_i[PAGE_BITS-1:0];
    end
    rdata_q <= tmem[raddr[TADDR_W-1:0]];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q         <= CAP_W'(4);
      lfsr_q        <= LFSR_W'(1);
      used_q        <= '0;
      fault_total_q <= '0;
      len_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_CAPACITY: cap_q <= cfg_data_i[CAP_W-1:0];
          CFG_SEED:     lfsr_q <= (cfg_data_i[LFSR_W-1:0] == '0) ? LFSR_W'(1)
                                                                 : cfg_data_i[LFSR_W-1:0];
          default: ;
        endcase
      end
      if (ctl_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (ctl_i.op)
        OP_LATCH: begin
          if (cmd_i == CMD_ACCESS && int'(len_q) < TRACE_DEPTH) len_q <= len_q + TLEN_W'(1);
        end
        OP_ACC_LOOK: begin
          if (!hit) begin
            fault_total_q <= fault_inc;
            if (used_q < cap_eff) begin
              used_q <= used_q + CNT_W'(1);
            end else begin
              lfsr_q <= lfsr_step;
            end
          end
        end
        OP_OPT_INIT: begin
          fault_total_q <= '0;
          used_q        <= '0;
        end
        OP_OPT_LOOK: begin
          if (!hit) begin
            fault_total_q <= fault_inc;
            if (used_q < cap_eff) used_q <= used_q + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    case (ctl_i.op)
      OP_LATCH: begin
        is_opt_q <= (cmd_i == CMD_RUN_OPT);
        pg_q     <= page_i[PAGE_BITS-1:0];
        fault_q  <= 1'b0;
        ovf_q    <= (cmd_i == CMD_ACCESS) && (int'(len_q) >= TRACE_DEPTH);
      end
      OP_ACC_LOOK: begin
        if (!hit) begin
          fault_q <= 1'b1;
          if (used_q < cap_eff) begin
            res_q[used_q[IDX_W-1:0]] <= pg_q;
          end else begin
            sh_q   <= lfsr_step;
            rem_q  <= '0;
            mcnt_q <= '0;
          end
        end
      end
      OP_MOD_STEP: begin
        rem_q  <= rem_d;
        sh_q   <= {sh_q[LFSR_W-2:0], 1'b0};
        mcnt_q <= mcnt_q + MCNT_W'(1);
      end
      OP_ACC_REPL: res_q[rem_q[IDX_W-1:0]] <= pg_q;
      OP_OPT_INIT: i_q <= '0;
      OP_LOAD_PG:  pg_q <= rdata_q;
      OP_OPT_LOOK: begin
        if (hit || used_q < cap_eff) begin
          // move to front / insert at front
          for (int j = 1; j < MAX_PAGES; j++) begin
            if (j <= int'(lim)) res_q[j] <= res_q[j-1];
          end
          res_q[0] <= pg_q;
        end else begin
          k_q     <= i_q + TLEN_W'(1);
          found_q <= '0;
          vj_q    <= '0;
          have_q  <= 1'b0;
        end
      end
      OP_NEXT_I: i_q <= i_q + TLEN_W'(1);
      OP_SCAN_CMP: begin
        for (int j = 0; j < MAX_PAGES; j++) begin
          if (j < int'(used_q) && !found_q[j] && res_q[j] == rdata_q) begin
            found_q[j] <= 1'b1;
            next_q[j]  <= k_q;
          end
        end
        k_q <= k_q + TLEN_W'(1);
      end
      OP_VSEL_STEP: begin
        if (!found_q[vj_q]) begin
          victim_q <= vj_q;
        end else if (!have_q || next_q[vj_q] > far_q) begin
          have_q   <= 1'b1;
          far_q    <= next_q[vj_q];
          victim_q <= vj_q;
        end
        vj_q <= vj_q + IDX_W'(1);
      end
      OP_OPT_REPL: begin
        for (int j = 0; j < MAX_PAGES - 1; j++) begin
          if (j >= int'(victim_q) && j + 1 < int'(used_q)) res_q[j] <= res_q[j+1];
        end
        res_q[last_idx] <= pg_q;
      end
      OP_OUT: begin
        o_fault_q <= fault_q;
        o_ovf_q   <= ovf_q;
        o_fcnt_q  <= fault_total_q;
        o_used_q  <= used_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign fault_o          = o_fault_q;
  assign fault_count_o    = o_fcnt_q;
  assign resident_count_o = RCNT_W'(o_used_q);
  assign trace_overflow_o = o_ovf_q;

  `PRRO_ASSERT(a_used_max, clk_i, rst_ni, int'(used_q) <= MAX_PAGES, "resident count above maximum")
  `PRRO_ASSERT(a_rem_range, clk_i, rst_ni, (ctl_i.op == OP_ACC_REPL) |-> (rem_q < cap_eff), "slot index not below capacity")
  `PRRO_ASSERT(a_victim_range, clk_i, rst_ni, (ctl_i.op == OP_OPT_REPL) |-> (CNT_W'(victim_q) < used_q), "victim outside resident list")
  `PRRO_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_q && out_stall_i) |=> $stable(o_fcnt_q), "result changed while stalled")

endmodule
`default_nettype wire

### rtl/page_replacement_random_and_opt_top.sv
// Access: a hit or a fill of a free slot goes straight to the result; when a
//   resident page is replaced, a 16-step LFSR remainder first picks the slot.
// Replay: trace items are read through the single trace read port and looked up;
//   an eviction scans the rest of the trace, then steps over the resident pages.
// One item at a time; a new item is taken while the previous result waits.
// Reset: capacity 4, LFSR 1, counts and trace length cleared; stores keep contents.
`default_nettype none
module page_replacement_random_and_opt_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [prro_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  logic [prro_pkg::CFG_W-1:0]   cfg_data_i,
  // item in
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [prro_pkg::PAGE_W-1:0]  page_i,
  // item out
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         fault_o,
  output logic [prro_pkg::FCNT_W-1:0]  fault_count_o,
  output logic [prro_pkg::RCNT_W-1:0]  resident_count_o,
  output logic                         trace_overflow_o
);
  import prro_pkg::*;

  // controller sequences the datapath one op per cycle
  prro_cmd_t  ctl;
  prro_stat_t stat;

  prro_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (ctl)
  );

  // resident list, trace store, LFSR, remainder unit, result register
  prro_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd_i),
    .page_i           (page_i),
    .ctl_i            (ctl),
    .stat_o           (stat),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .fault_o          (fault_o),
    .fault_count_o    (fault_count_o),
    .resident_count_o (resident_count_o),
    .trace_overflow_o (trace_overflow_o)
  );

endmodule
`default_nettype wire
